// File: hdl/clkrep_pkg.sv
`timescale 1ns / 1ps

package clkrep_pkg;

  // Frame count and effective limit (1..511 fits in 9 bits)
  typedef logic [8:0] cnt_t;
  // Frame index as seen on the ports
  typedef logic [7:0] frame_t;

  // Transaction kinds
  localparam logic KIND_REFERENCE = 1'b0;
  localparam logic KIND_EVICT     = 1'b1;

  // Reset value of the frame count register
  localparam cnt_t FIU_RESET = 9'd256;

  // Command from the top level to the walker
  typedef struct packed {
    logic   start;
    logic   kind;
    frame_t frame_index;
  } cmd_t;

  // Result from the walker
  typedef struct packed {
    logic   valid;
    frame_t victim;
  } res_t;

endpackage

// File: hdl/clkrep_ram.sv
`timescale 1ns / 1ps

module clkrep_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/clkrep_walk.sv
`timescale 1ns / 1ps

module clkrep_walk #(
  parameter int MAXLIM = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  clkrep_pkg::cnt_t   limit,
  input  clkrep_pkg::cmd_t   cmd,
  output logic               busy,
  output clkrep_pkg::res_t   res
);

  import clkrep_pkg::*;

  localparam int POS_W = $clog2(MAXLIM);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAXLIM - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] clr_r, clr_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  frame_t           hand_r, hand_nxt;
  logic             out_valid_r, out_valid_nxt;
  frame_t           out_victim_r, out_victim_nxt;

  logic             wr_en;
  logic [POS_W-1:0] wr_addr;
  logic             wr_data;
  logic [POS_W-1:0] rd_addr;
  logic             rd_data;

  logic             accept;
  logic [31:0]      frame_ext;
  logic [31:0]      hand_ext;
  logic [31:0]      pos_ext;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] pos_adv;

  // Next position, wrapping at the limit
  function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] p, input cnt_t lim);
    logic [31:0] nxt;
    nxt = 32'(p) + 32'd1;
    if (nxt >= 32'(lim)) begin
      nxt = '0;
    end
    return nxt[POS_W-1:0];
  endfunction

  assign accept    = cmd.start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign frame_ext = 32'(cmd.frame_index);
  assign hand_ext  = 32'(hand_r);
  assign pos_ext   = 32'(pos_r);
  assign pos_adv   = advance(pos_r, limit);

  // Walk starts at the hand, or at frame 0 if the hand is past the limit
  assign start_pos = (hand_ext >= 32'(limit)) ? '0 : hand_ext[POS_W-1:0];

  // Read the start position while idle, otherwise the current position
  assign rd_addr = (state_r == S_IDLE) ? start_pos : pos_r;

  // Write port: clearing pass, reference set, or walk update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = 1'b0;
      end
      S_IDLE: begin
        if (accept && (cmd.kind == KIND_REFERENCE) && (frame_ext < 32'(limit))) begin
          wr_en   = 1'b1;
          wr_addr = frame_ext[POS_W-1:0];
          wr_data = 1'b1;
        end
      end
      S_CHECK: begin
        // set bit gets its second chance cleared; clear bit marks the victim
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = !rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    pos_nxt        = pos_r;
    hand_nxt       = hand_r;
    out_valid_nxt  = 1'b0;
    out_victim_nxt = out_victim_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + POS_W'(1);
        if (clr_r == LAST_POS) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && (cmd.kind == KIND_EVICT)) begin
          pos_nxt   = start_pos;
          state_nxt = S_CHECK;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (rd_data) begin
          pos_nxt   = pos_adv;
          state_nxt = S_READ;
        end else begin
          hand_nxt       = frame_t'(pos_adv);
          out_valid_nxt  = 1'b1;
          out_victim_nxt = pos_ext[7:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pos_r       <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pos_r       <= pos_nxt;
      hand_r      <= hand_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_victim_r <= out_victim_nxt;
  end

  assign res.valid  = out_valid_r;
  assign res.victim = out_victim_r;

  clkrep_ram #(
    .WIDTH (1),
    .DEPTH (MAXLIM)
  ) u_bits (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

`ifndef NO_ASSERTIONS
  // A result only follows a look that found a clear bit
  a_res_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_CHECK))
    else $error("result without a completed walk");

  // Results are single-cycle strobes, one per eviction
  a_res_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // An accepted eviction looks at its first frame on the next cycle
  a_evict_check: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd.kind == KIND_EVICT)) |=> (state_r == S_CHECK))
    else $error("eviction did not start its walk");

  // No bit store write while a read is in flight
  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !wr_en)
    else $error("write during walk read");
`endif

endmodule

// File: hdl/clock_page_replacement_core.sv
`timescale 1ns / 1ps

// Second-chance (clock) page replacement engine. A transaction is taken when
// start is high and busy is low. A reference (in_kind 0) sets the frame's
// reference bit and gives no result. An eviction (in_kind 1) walks the bit
// store from the clock hand and strobes out_valid for one cycle with
// out_victim_frame; the receiver cannot stall, so the result must be
// captured in that cycle. The bits live in a memory with one registered read
// port; the walk clears each set bit it skips (at most the frame count of
// them) and stops at the first clear bit. After reset a clearing pass writes
// every entry of the bit store, min(FRAMES, 511) of them, while busy is high;
// configuration writes are taken at any time, but are meant for idle periods.
module clock_page_replacement_core #(
  parameter int FRAMES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_kind,
  input  logic [7:0] in_frame_index,
  output logic       out_valid,
  output logic [7:0] out_victim_frame,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data
);

  import clkrep_pkg::*;

  // Frames reachable: the count register cannot exceed 511
  localparam int   MAXLIM    = (FRAMES < 511) ? FRAMES : 511;
  localparam cnt_t FRAMES_CAP = cnt_t'(MAXLIM);

  cnt_t fiu_r;
  cnt_t limit;
  cmd_t cmd;
  res_t res;

  // Frame count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r <= FIU_RESET;
    end else if (cfg_wr_en) begin
      fiu_r <= cfg_wr_data;
    end
  end

  // Effective limit: zero acts as one, saturate at MAXLIM, the frame capacity
  always_comb begin
    if (fiu_r == '0) begin
      limit = cnt_t'(1);
    end else if (32'(fiu_r) > 32'(MAXLIM)) begin
      limit = FRAMES_CAP;
    end else begin
      limit = fiu_r;
    end
  end

  assign cmd.start       = start;
  assign cmd.kind        = in_kind;
  assign cmd.frame_index = in_frame_index;

  clkrep_walk #(
    .MAXLIM (MAXLIM)
  ) u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .limit (limit),
    .cmd   (cmd),
    .busy  (busy),
    .res   (res)
  );

  assign out_valid        = res.valid;
  assign out_victim_frame = res.victim;

endmodule
